// ----- rtl/core/bmpu_pkg.sv -----
package bmpu_pkg;

  // size limits
  localparam int MAX_WIDTH       = 1024;
  localparam int MAX_HEIGHT      = 1024;
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  // field widths
  localparam int DIM_W   = 11;
  localparam int BPP_W   = 6;
  localparam int IDX_W   = 20;
  localparam int COLOR_W = 24;
  localparam int BYTE_W  = 8;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  // register indexes (paddr word address)
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BPP    = 2'd2;

  // register reset values
  localparam logic [DIM_W-1:0] RST_WIDTH  = 11'd1;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd1;
  localparam logic [BPP_W-1:0] RST_BPP    = 6'd8;

  // supported depths
  localparam logic [BPP_W-1:0] BPP_1  = 6'd1;
  localparam logic [BPP_W-1:0] BPP_4  = 6'd4;
  localparam logic [BPP_W-1:0] BPP_8  = 6'd8;
  localparam logic [BPP_W-1:0] BPP_24 = 6'd24;
  localparam logic [BPP_W-1:0] BPP_32 = 6'd32;

  // transaction kinds
  localparam logic MODE_PAL  = 1'b0;
  localparam logic MODE_DATA = 1'b1;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [BPP_W-1:0] bpp;
  } cfg_t;

endpackage

// ----- rtl/core/bmpu_ram.sv -----
module bmpu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // output holds while no read is issued
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/bmpu_regs.sv -----
module bmpu_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bmpu_pkg::APB_AW-1:0] paddr,
  input  logic [bmpu_pkg::APB_DW-1:0] pwdata,
  output logic [bmpu_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output bmpu_pkg::cfg_t             cfg
);
  import bmpu_pkg::*;

  logic [DIM_W-1:0] width_r;
  logic [DIM_W-1:0] height_r;
  logic [BPP_W-1:0] bpp_r;
  logic             wr_en;
  logic [1:0]       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      bpp_r    <= RST_BPP;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_WIDTH:  width_r  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: height_r <= pwdata[DIM_W-1:0];
        REG_BPP:    bpp_r    <= pwdata[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = APB_DW'(width_r);
      REG_HEIGHT: prdata = APB_DW'(height_r);
      REG_BPP:    prdata = APB_DW'(bpp_r);
      default:    prdata = '0;
    endcase
  end

  // sizes saturate at the supported maximum
  always_comb begin
    cfg.width  = (int'(width_r) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_r;
    cfg.height = (int'(height_r) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_r;
    cfg.bpp    = bpp_r;
  end

endmodule

// ----- rtl/core/bmp_pixel_unpacker.sv -----
// Bitmap pixel unpacker. Accepts bitmap pixel data one byte per in_ transaction
// (in_mode = 1) and palette loads (in_mode = 0), and returns 24-bit blue/green/red
// pixels on out_ together with their position in a top-down frame buffer,
// (height-1-row)*width + column, since bitmap rows arrive bottom-up. Depths 1, 4
// and 8 look up the 256-entry palette, 24 assembles three bytes and 32 drops
// every fourth byte; row padding up to a 4-byte boundary gives no pixel, and an
// unsupported depth gives one transaction with out_depth_error set. Palette
// entries must be loaded before they are used. Rate: palette loads, padding
// bytes and bytes at depth 8, 24 or 32 stream back to back, those that give a
// pixel only while stage b has room; a depth-4 or depth-1 byte is stepped through
// one pixel per cycle while stage b has room, set by the single read port of the
// palette memory. A pixel passes stage b and the output register to reach out_.
// Registers
// (psel/penable/pwrite APB write, always ready): 0x0 image_width, 0x4
// image_height, 0x8 bits_per_pixel; write them only while the block is idle.
module bmp_pixel_unpacker (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bmpu_pkg::APB_AW-1:0] paddr,
  input  logic [bmpu_pkg::APB_DW-1:0] pwdata,
  output logic [bmpu_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [7:0]                  in_byte_value,
  input  logic [7:0]                  in_palette_index,
  input  logic [23:0]                 in_palette_color,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [19:0]                 out_pixel_index,
  output logic [7:0]                  out_blue,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_red,
  output logic                        out_last_of_run,
  output logic                        out_image_done,
  output logic                        out_depth_error
);
  import bmpu_pkg::*;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  cfg_t cfg;

  bmpu_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------------
  // stage a: holds one transaction, steps its pixels while b has room, one per cycle
  // ---------------------------------------------------------------------------
  logic                a_valid_r;
  logic                a_mode_r;
  logic [BYTE_W-1:0]   a_byte_r;
  logic [BYTE_W-1:0]   a_pidx_r;
  logic [COLOR_W-1:0]  a_pcol_r;

  // scan position and pixel assembly state
  logic [DIM_W-1:0]    col_r,   col_nxt;
  logic [DIM_W-1:0]    row_r,   row_nxt;
  logic [1:0]          bip_r,   bip_nxt;     // byte within a 24/32-bit pixel
  logic [15:0]         held_r,  held_nxt;    // blue low byte, green high byte
  logic [1:0]          phase_r, phase_nxt;   // bytes of the row, modulo 4
  logic [2:0]          step_r,  step_nxt;    // pixel within the current byte

  logic                depth_ok;
  logic                a_emit;
  logic                a_use_pal;
  logic                a_err;
  logic                a_done;
  logic                a_go;
  logic                data_byte;
  logic [BYTE_W-1:0]   pal_idx;
  logic                pal_ok;
  logic [COLOR_W-1:0]  direct_color;
  logic                col_lt_w;
  logic                col_last;
  logic                row_last;
  logic [IDX_W-1:0]    row_span;
  logic [IDX_W+DIM_W-1:0] row_prod;

  logic                ram_we;
  logic                ram_re;
  logic [COLOR_W-1:0]  ram_rdata;

  // stage b / output stage handshakes
  logic                b_valid_r;
  logic                b_adv;
  logic                c_can;

  always_comb begin
    unique case (cfg.bpp) inside
      BPP_1, BPP_4, BPP_8, BPP_24, BPP_32: depth_ok = 1'b1;
      default:                             depth_ok = 1'b0;
    endcase
  end

  assign col_lt_w = col_r < cfg.width;
  assign col_last = ({1'b0, col_r} + 12'd1) >= {1'b0, cfg.width};
  assign row_last = ({1'b0, row_r} + 12'd1) >= {1'b0, cfg.height};

  // row base of the top-down frame buffer, modulo 2^20
  assign row_span = IDX_W'(cfg.height) - IDX_W'(1) - IDX_W'(row_r);
  assign row_prod = row_span * cfg.width;

  // what this cycle's step of the held transaction does
  always_comb begin
    a_emit       = 1'b0;
    a_use_pal    = 1'b0;
    a_err        = 1'b0;
    a_done       = 1'b1;
    data_byte    = 1'b0;
    pal_idx      = '0;
    direct_color = '0;
    col_nxt      = col_r;
    bip_nxt      = bip_r;
    held_nxt     = held_r;
    step_nxt     = '0;

    if (a_mode_r == MODE_PAL) begin
      // palette load: memory write only
    end else if (!depth_ok) begin
      a_emit = 1'b1;
      a_err  = 1'b1;
    end else begin
      data_byte = 1'b1;
      if (cfg.bpp == BPP_32 && bip_r == 2'd3) begin
        bip_nxt = 2'd0;                       // alpha byte is dropped
      end else if (!col_lt_w) begin
        bip_nxt = 2'd0;                       // row padding
      end else begin
        case (cfg.bpp)
          BPP_1: begin
            bip_nxt   = 2'd0;
            a_emit    = 1'b1;
            a_use_pal = 1'b1;
            pal_idx   = BYTE_W'(a_byte_r[3'd7 - step_r]);
            a_done    = (step_r == 3'd7) || col_last;
            step_nxt  = step_r + 3'd1;
          end
          BPP_4: begin
            bip_nxt   = 2'd0;
            a_emit    = 1'b1;
            a_use_pal = 1'b1;
            pal_idx   = step_r[0] ? BYTE_W'(a_byte_r[3:0]) : BYTE_W'(a_byte_r[7:4]);
            a_done    = step_r[0] || col_last;
            step_nxt  = step_r + 3'd1;
          end
          BPP_8: begin
            bip_nxt   = 2'd0;
            a_emit    = 1'b1;
            a_use_pal = 1'b1;
            pal_idx   = a_byte_r;
          end
          default: begin
            // 24 and 32 bit: blue, green, then red completes the pixel
            case (bip_r)
              2'd0: begin
                held_nxt = {8'd0, a_byte_r};
                bip_nxt  = 2'd1;
              end
              2'd1: begin
                held_nxt = {a_byte_r, held_r[7:0]};
                bip_nxt  = 2'd2;
              end
              default: begin
                a_emit       = 1'b1;
                direct_color = {a_byte_r, held_r};
                bip_nxt      = (cfg.bpp == BPP_32) ? 2'd3 : 2'd0;
              end
            endcase
          end
        endcase
      end
      if (a_emit) begin
        col_nxt = col_r + DIM_W'(1);
      end
    end
  end

  assign pal_ok = int'(pal_idx) < PALETTE_ENTRIES;

  // row end check after the last step of a data byte
  always_comb begin
    phase_nxt = phase_r + 2'd1;
    row_nxt   = row_r;
    if (col_nxt >= cfg.width && bip_nxt == 2'd0 && phase_nxt == 2'd0) begin
      row_nxt = row_last ? '0 : row_r + DIM_W'(1);
    end
  end

  // a step that produces a result waits for room in stage b
  assign a_go     = a_valid_r && (!a_emit || b_adv);
  assign in_ready = !a_valid_r || (a_go && a_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_mode_r <= in_mode;
      a_byte_r <= in_byte_value;
      a_pidx_r <= in_palette_index;
      a_pcol_r <= in_palette_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      bip_r   <= '0;
      held_r  <= '0;
      phase_r <= '0;
      step_r  <= '0;
    end else if (a_go) begin
      bip_r  <= bip_nxt;
      held_r <= held_nxt;
      step_r <= a_done ? 3'd0 : step_nxt;
      if (data_byte && a_done) begin
        phase_r <= phase_nxt;
        if (col_nxt >= cfg.width && bip_nxt == 2'd0 && phase_nxt == 2'd0) begin
          col_r <= '0;
          row_r <= row_nxt;
        end else begin
          col_r <= col_nxt;
        end
      end else begin
        col_r <= col_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // palette memory: loads write in transaction order, lookups read one per cycle
  // ---------------------------------------------------------------------------
  assign ram_we = a_valid_r && (a_mode_r == MODE_PAL) && (int'(a_pidx_r) < PALETTE_ENTRIES);
  assign ram_re = a_go && a_emit && a_use_pal;

  bmpu_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (a_pidx_r[PAL_AW-1:0]),
    .wdata (a_pcol_r),
    .re    (ram_re),
    .raddr (pal_idx[PAL_AW-1:0]),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // stage b: waits for the palette read, carries the pixel's metadata
  // ---------------------------------------------------------------------------
  logic               b_use_pal_r;
  logic               b_pal_ok_r;
  logic [COLOR_W-1:0] b_color_r;
  logic [IDX_W-1:0]   b_base_r;
  logic [DIM_W-1:0]   b_col_r;
  logic               b_last_r;
  logic               b_img_done_r;
  logic               b_err_r;

  assign b_adv = !b_valid_r || c_can;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_adv) begin
      b_valid_r <= a_go && a_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv && a_go && a_emit) begin
      b_use_pal_r  <= a_use_pal;
      b_pal_ok_r   <= pal_ok;
      b_color_r    <= direct_color;
      b_last_r     <= a_done;
      b_err_r      <= a_err;
      // the error transaction carries zero position and color
      b_base_r     <= a_err ? '0 : row_prod[IDX_W-1:0];
      b_col_r      <= a_err ? '0 : col_r;
      b_img_done_r <= !a_err && row_last && col_last;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  logic               out_valid_r;
  logic [IDX_W-1:0]   out_index_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_last_r;
  logic               out_img_done_r;
  logic               out_err_r;

  assign c_can = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (c_can) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_can && b_valid_r) begin
      out_index_r    <= b_base_r + IDX_W'(b_col_r);
      out_color_r    <= b_use_pal_r ? (b_pal_ok_r ? ram_rdata : '0) : b_color_r;
      out_last_r     <= b_last_r;
      out_img_done_r <= b_img_done_r;
      out_err_r      <= b_err_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_index_r;
  assign out_blue        = out_color_r[7:0];
  assign out_green       = out_color_r[15:8];
  assign out_red         = out_color_r[23:16];
  assign out_last_of_run = out_last_r;
  assign out_image_done  = out_img_done_r;
  assign out_depth_error = out_err_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // an error transaction is alone for its byte and carries no pixel
  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_depth_error |->
      out_last_of_run && !out_image_done && out_pixel_index == '0)
    else $error("depth error transaction carries pixel data");

  // a palette load and a lookup never share the memory in one cycle
  a_ram_excl: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re)
    else $error("palette write and read in the same cycle");

  // a lookup lands in stage b so its read data is consumed there
  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> b_valid_r && b_use_pal_r)
    else $error("palette read without a waiting pixel");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import bmpu_pkg::*;

  // run limits
  localparam int CYCLE_LIMIT  = 200000;
  // covers a transaction's path from acceptance to out_ and the pixels of a depth-1 byte
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 240;
  localparam logic [31:0] DIM_MASK = 32'h7FF;
  localparam logic [31:0] BPP_MASK = 32'h3F;

  // one pixel transaction on the result channel
  typedef struct packed {
    logic [19:0] index;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        last;
    logic        done;
    logic        err;
  } pixel_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic                in_mode;
  logic [7:0]          in_byte_value;
  logic [7:0]          in_palette_index;
  logic [23:0]         in_palette_color;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [19:0]         out_pixel_index;
  logic [7:0]          out_blue;
  logic [7:0]          out_green;
  logic [7:0]          out_red;
  logic                out_last_of_run;
  logic                out_image_done;
  logic                out_depth_error;

  // idle percentages of the two sides, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long receiver hold-off: the stimulus bumps hold_req, the receiver counts it down
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int cycle_count = 0;
  int mismatches  = 0;

  // shadow of the block: configuration, palette and unpacking state
  int unsigned      img_width;
  int unsigned      img_height;
  logic [BPP_W-1:0] img_bpp;
  logic [23:0]      pal_color [PALETTE_ENTRIES];
  bit               pal_loaded [PALETTE_ENTRIES];
  logic [7:0]       loaded_entries [$];
  int unsigned      col_cnt;
  int unsigned      row_cnt;
  int unsigned      byte_pos;
  logic [15:0]      held_bytes;
  int unsigned      row_phase;

  // pixels still owed by the block, oldest first
  pixel_t expected_pixels [$];
  // pixels caused by the byte being unpacked
  pixel_t run_px [8];
  int     run_len;
  pixel_t want;

  bmp_pixel_unpacker u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_byte_value    (in_byte_value),
    .in_palette_index (in_palette_index),
    .in_palette_color (in_palette_color),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_index  (out_pixel_index),
    .out_blue         (out_blue),
    .out_green        (out_green),
    .out_red          (out_red),
    .out_last_of_run  (out_last_of_run),
    .out_image_done   (out_image_done),
    .out_depth_error  (out_depth_error)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // cycle limit, ends a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // pixel predictor
  // ---------------------------------------------------------------------------

  function automatic bit depth_supported(input logic [BPP_W-1:0] bpp);
    case (bpp)
      BPP_1, BPP_4, BPP_8, BPP_24, BPP_32: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // entries beyond the palette read as black
  function automatic logic [23:0] palette_lookup(input logic [7:0] idx);
    if (idx >= PALETTE_ENTRIES) begin
      return 24'h000000;
    end
    return pal_color[idx];
  endfunction

  // one pixel at the current column; rows arrive bottom-up, so the frame
  // buffer row is height-1-row, all modulo 2^20
  task automatic emit_pixel(input logic [23:0] bgr, input int unsigned w,
                            input int unsigned h);
    logic [31:0] row_base;
    logic [31:0] pos;
    pixel_t      px;
    row_base = (h - 1 - row_cnt) * w;
    pos = row_base + col_cnt;
    px.index = pos[19:0];
    px.blue = bgr[7:0];
    px.green = bgr[15:8];
    px.red = bgr[23:16];
    px.last = 1'b0;
    px.done = (row_cnt + 1 >= h) && (col_cnt + 1 >= w);
    px.err = 1'b0;
    col_cnt = (col_cnt + 1) & DIM_MASK;
    run_px[run_len] = px;
    run_len++;
  endtask

  // works out the pixels one accepted transaction causes
  task automatic unpack_item(input logic mode, input logic [7:0] b,
                             input logic [7:0] pidx, input logic [23:0] pcolor);
    int unsigned w;
    int unsigned h;
    pixel_t      err_px;
    int          i;
    w = (img_width > MAX_WIDTH) ? MAX_WIDTH : img_width;
    h = (img_height > MAX_HEIGHT) ? MAX_HEIGHT : img_height;
    run_len = 0;
    if (mode == MODE_PAL) begin
      if (pidx < PALETTE_ENTRIES) begin
        pal_color[pidx] = pcolor;
        if (!pal_loaded[pidx]) begin
          pal_loaded[pidx] = 1'b1;
          loaded_entries.push_back(pidx);
        end
      end
    end else if (!depth_supported(img_bpp)) begin
      // unsupported depth: one error flag, state untouched
      err_px = '0;
      err_px.last = 1'b1;
      err_px.err = 1'b1;
      run_px[0] = err_px;
      run_len = 1;
    end else begin
      if (img_bpp == BPP_32 && byte_pos == 3) begin
        byte_pos = 0;
      end else if (col_cnt >= w) begin
        byte_pos = 0;
      end else if (img_bpp == BPP_1) begin
        byte_pos = 0;
        for (i = 7; i >= 0; i--) begin
          if (col_cnt < w) begin
            emit_pixel(palette_lookup((b >> i) & 8'h01), w, h);
          end
        end
      end else if (img_bpp == BPP_4) begin
        byte_pos = 0;
        emit_pixel(palette_lookup(b >> 4), w, h);
        if (col_cnt < w) begin
          emit_pixel(palette_lookup(b & 8'h0F), w, h);
        end
      end else if (img_bpp == BPP_8) begin
        byte_pos = 0;
        emit_pixel(palette_lookup(b), w, h);
      end else begin
        // blue, green, then red completes the pixel
        if (byte_pos == 0) begin
          held_bytes = {8'h00, b};
          byte_pos = 1;
        end else if (byte_pos == 1) begin
          held_bytes = {b, held_bytes[7:0]};
          byte_pos = 2;
        end else begin
          emit_pixel({b, held_bytes}, w, h);
          byte_pos = (img_bpp == BPP_32) ? 3 : 0;
        end
      end
      row_phase = (row_phase + 1) & 3;
      if (col_cnt >= w && byte_pos == 0 && row_phase == 0) begin
        col_cnt = 0;
        row_cnt = (row_cnt + 1 >= h) ? 0 : ((row_cnt + 1) & DIM_MASK);
      end
    end
    if (run_len > 0) begin
      run_px[run_len - 1].last = 1'b1;
    end
    for (i = 0; i < run_len; i++) begin
      expected_pixels.push_back(run_px[i]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [23:0] want_v,
                             input logic [23:0] got_v);
    if (want_v !== got_v) begin
      mismatches++;
      $display("%0t %s expected %0h actual %0h", $time, name, want_v, got_v);
    end
  endtask

  // every accepted result transaction is matched against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $display("%0t unexpected pixel expected none actual index %0h", $time,
                 out_pixel_index);
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_index", 24'(want.index), 24'(out_pixel_index));
        check_field("blue", 24'(want.blue), 24'(out_blue));
        check_field("green", 24'(want.green), 24'(out_green));
        check_field("red", 24'(want.red), 24'(out_red));
        check_field("last_of_run", 24'(want.last), 24'(out_last_of_run));
        check_field("image_done", 24'(want.done), 24'(out_image_done));
        check_field("depth_error", 24'(want.err), 24'(out_depth_error));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offers one transaction, with a random gap first; valid stays high across
  // back-to-back transactions and is lowered only for a gap or by drain_pixels
  task automatic send_item(input logic mode, input logic [7:0] b,
                           input logic [7:0] pidx, input logic [23:0] pcolor);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_byte_value <= b;
    in_palette_index <= pidx;
    in_palette_color <= pcolor;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    unpack_item(mode, b, pidx, pcolor);
  endtask

  // unused fields carry random values
  task automatic send_data(input logic [7:0] b);
    send_item(MODE_DATA, b, 8'($urandom()), 24'($urandom()));
  endtask

  task automatic send_load(input logic [7:0] pidx, input logic [23:0] pcolor);
    send_item(MODE_PAL, 8'($urandom()), pidx, pcolor);
  endtask

  // waits until every owed pixel has arrived and the block has settled
  task automatic drain_pixels;
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup and access cycle; bits above the register get random values
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] keep;
    keep = (idx == REG_BPP) ? BPP_MASK : DIM_MASK;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom() & ~keep) | (value & keep);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WIDTH:  img_width = value & keep;
      REG_HEIGHT: img_height = value & keep;
      REG_BPP:    img_bpp = value[BPP_W-1:0];
      default: ;
    endcase
  endtask

  // new image geometry, written only with the block idle
  task automatic set_image(input int unsigned w, input int unsigned h,
                           input logic [BPP_W-1:0] bpp);
    drain_pixels();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_BPP, {26'd0, bpp});
  endtask

  // at depth 8 every byte may be looked up, so only loaded entries are sent
  function automatic logic [7:0] random_data_byte;
    logic [7:0] v;
    v = 8'($urandom());
    if (img_bpp == BPP_8) begin
      v = loaded_entries[$urandom_range(loaded_entries.size() - 1)];
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // entries 0..15 cover every depth-1 and depth-4 lookup; 128 and 255 reach
  // the upper index bits
  task automatic test_palette_load;
    int i;
    for (i = 0; i < 16; i++) begin
      if (i == 0) begin
        send_load(8'(i), 24'h000000);
      end else if (i == 15) begin
        send_load(8'(i), 24'hFFFFFF);
      end else begin
        send_load(8'(i), 24'($urandom()));
      end
    end
    send_load(8'd128, 24'($urandom()));
    send_load(8'd255, 24'($urandom()));
  endtask

  // 3x2 image at depth 8: one padding byte per row, bottom row lands at
  // index 3..5, the last pixel flags image done
  task automatic test_depth8_frame;
    set_image(3, 2, BPP_8);
    send_data(8'd0);
    send_data(8'd15);
    send_data(8'd7);
    send_data(8'hFF);
    send_data(8'd1);
    send_data(8'd2);
    send_data(8'd3);
    send_data(8'h80);
  endtask

  // 9 pixels at depth 1: a full byte, then a byte cut short by the row end
  task automatic test_depth1_row;
    set_image(9, 1, BPP_1);
    send_data(8'hA5);
    send_data(8'h80);
    send_data(8'hFF);
    send_data(8'h00);
  endtask

  // odd width at depth 4: the second byte's low nibble falls past the row end
  task automatic test_depth4_row;
    set_image(3, 1, BPP_4);
    send_data(8'h0F);
    send_data(8'hF0);
    send_data(8'h5A);
    send_data(8'hC3);
  endtask

  task automatic test_depth24_pixel;
    set_image(1, 1, BPP_24);
    send_data(8'h00);
    send_data(8'hFF);
    send_data(8'h5A);
    send_data(8'hA5);
  endtask

  // fourth byte of each pixel is dropped
  task automatic test_depth32_pixel;
    set_image(1, 1, BPP_32);
    send_data(8'hFF);
    send_data(8'h00);
    send_data(8'hA5);
    send_data(8'h3C);
  endtask

  task automatic test_unsupported_depth;
    set_image(1, 1, 6'd0);
    send_data(8'h12);
    set_image(1, 1, 6'd63);
    send_data(8'hED);
    set_image(1, 1, 6'd2);
    send_data(8'h77);
  endtask

  // zero width makes every byte padding; oversized width and height saturate
  task automatic test_size_extremes;
    set_image(0, 0, BPP_8);
    send_data(8'd4);
    send_data(8'd9);
    set_image(2047, 2047, BPP_24);
    send_data(8'h81);
    send_data(8'h7E);
    send_data(8'hC0);
  endtask

  // random geometry and depth per stretch, mostly pixel bytes with some
  // palette loads mixed in; state carries over between stretches
  task automatic test_random_traffic(input int n_items);
    int               sent;
    int               len;
    int               r;
    int unsigned      w;
    int unsigned      h;
    logic [BPP_W-1:0] bpp;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 15) begin
        bpp = BPP_1;
      end else if (r < 30) begin
        bpp = BPP_4;
      end else if (r < 50) begin
        bpp = BPP_8;
      end else if (r < 70) begin
        bpp = BPP_24;
      end else if (r < 88) begin
        bpp = BPP_32;
      end else begin
        bpp = 6'($urandom_range(63));
      end
      r = $urandom_range(99);
      if (r < 80) begin
        w = $urandom_range(12);
      end else if (r < 92) begin
        w = $urandom_range(48, 13);
      end else begin
        case ($urandom_range(2))
          0: w = MAX_WIDTH;
          1: w = MAX_WIDTH + 1;
          default: w = 2047;
        endcase
      end
      r = $urandom_range(99);
      if (r < 85) begin
        h = $urandom_range(4);
      end else begin
        case ($urandom_range(2))
          0: h = MAX_HEIGHT;
          1: h = 2047;
          default: h = $urandom_range(2047, 5);
        endcase
      end
      set_image(w, h, bpp);
      len = $urandom_range(24, 8);
      repeat (len) begin
        if ($urandom_range(99) < 12) begin
          send_load(8'($urandom()), 24'($urandom()));
        end else begin
          send_data(random_data_byte());
        end
      end
      sent += len;
    end
  endtask

  // receiver holds off while depth-1 bytes keep coming, so the block fills
  // up and has to stall its input
  task automatic test_backpressure;
    set_image(32, 2, BPP_1);
    hold_req++;
    repeat (24) send_data(8'($urandom()));
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_mode = MODE_PAL;
    in_byte_value = '0;
    in_palette_index = '0;
    in_palette_color = '0;
    // shadow state after reset
    img_width = 32'(RST_WIDTH);
    img_height = 32'(RST_HEIGHT);
    img_bpp = RST_BPP;
    col_cnt = 0;
    row_cnt = 0;
    byte_pos = 0;
    held_bytes = '0;
    row_phase = 0;
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      pal_color[i] = '0;
      pal_loaded[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles lightly, receiver heavily
    send_idle_pct = 28;
    recv_idle_pct = 63;
    test_palette_load();
    test_depth8_frame();
    test_depth1_row();
    test_depth4_row();
    test_depth24_pixel();
    test_depth32_pixel();
    test_unsupported_depth();
    test_size_extremes();
    test_random_traffic(RANDOM_ITEMS / 3);

    // the other way round
    send_idle_pct = 63;
    recv_idle_pct = 28;
    test_random_traffic(RANDOM_ITEMS / 3);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(RANDOM_ITEMS / 3);
    test_backpressure();

    drain_pixels();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/bmpu_pkg.sv
rtl/core/bmpu_ram.sv
rtl/core/bmpu_regs.sv
rtl/core/bmp_pixel_unpacker.sv
tb/tb.sv
